>>> src/phsh_pkg.sv
// ----------------------------------------------------------------------------
// Path string hash: shared package
// Entry format between front and back units, hash constants, CSR codes.
// ----------------------------------------------------------------------------
package phsh_pkg;

   localparam logic [31:0] GOLDEN      = 32'h9E3779B9;
   localparam int          BLOCK_BYTES = 12;
   localparam int          SLOT_W      = 4;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BLOCK_BYTES - 1);
   localparam int          QUEUE_DEPTH = 4;

   typedef enum logic {
      CSR_SEED      = 1'b0,
      CSR_NORMALIZE = 1'b1
   } csr_index_type;

   // One queued item: a byte (folded when normalizing) and/or an end-of-string marker
   typedef struct packed {
      logic [7:0]        data;
      logic [SLOT_W-1:0] slot;   // block position of data, or tail fill when no byte
      logic              take;   // data belongs to the string
      logic              last;
      logic              first;  // first item of a string: reload hash words
      logic [31:0]       total;  // byte count including this item
   } entry_type;

endpackage

>>> src/path_string_hash_unit.sv
// ----------------------------------------------------------------------------
// Path string hash unit
// Streaming lookup2-style 32-bit string hash with optional path normalization.
// ----------------------------------------------------------------------------
// Bytes are accepted one per cycle while the queue has room. A 4-entry queue
// separates the front unit (folding, truncation, length count) from the back
// unit, which runs the mix one step per cycle; the mix of each completed
// 12-byte block overlaps the arrival of the next block, so long strings stream
// at one byte per cycle. The string end costs a final mix (preceded by the
// block mix and a length add when the final item carries the byte that
// completes a block); items of the next string wait in the queue meanwhile,
// so short strings are bound by the final mix rather than by the input rate.
// The result register lets a new string proceed while a hash waits to be taken.
// ----------------------------------------------------------------------------
module path_string_hash_unit #(
   parameter int MAX_NORM_LEN = 1023
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  phsh_pkg::csr_index_type  csr_index,
   input  logic [31:0]              csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_byte_present,
   input  logic                     req_last,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [31:0]              rsp_hash_value
);
   import phsh_pkg::*;

   logic [31:0] seed_ff;
   logic        normalize_ff;

   logic        push, pop, queue_full, head_valid;
   entry_type   push_entry, head_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         normalize_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SEED:      seed_ff      <= csr_wdata;
            CSR_NORMALIZE: normalize_ff <= csr_wdata[0];
            default:       ;
         endcase
      end
   end

   phsh_front #(
      .MAX_NORM_LEN(MAX_NORM_LEN)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .normalize        (normalize_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_last         (req_last),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   phsh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   phsh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .seed           (seed_ff),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

>>> src/phsh_front.sv
// ----------------------------------------------------------------------------
// Path string hash: front unit
// Accepts request items, folds bytes and applies truncation when normalizing,
// tracks block position and length, and queues work for the back unit.
// ----------------------------------------------------------------------------
module phsh_front #(
   parameter int MAX_NORM_LEN = 1023
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 normalize,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_byte_present,
   input  logic                 req_last,
   input  logic                 queue_full,
   output logic                 push,
   output phsh_pkg::entry_type  push_entry
);
   import phsh_pkg::*;

   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_CASE    = 8'h20;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_BSLASH  = 8'h5C;

   logic              active_ff, active_in;
   logic [SLOT_W-1:0] fill_ff, fill_in;
   logic [31:0]       total_ff, total_in;

   logic              accept;
   logic              start;
   logic [SLOT_W-1:0] fill_cur;
   logic [31:0]       total_cur;
   logic              take;
   logic [7:0]        data_folded;

   function automatic logic [7:0] fold(input logic [7:0] v);
      logic [7:0] r;
      r = v;
      if (v >= CHAR_LOWER_A && v <= CHAR_LOWER_Z) begin
         r = v - CHAR_CASE;
      end else if (v == CHAR_SLASH) begin
         r = CHAR_BSLASH;
      end
      return r;
   endfunction

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign start     = !active_ff;
   assign fill_cur  = start ? '0 : fill_ff;
   assign total_cur = start ? '0 : total_ff;
   assign take      = req_byte_present && !(normalize && total_cur >= 32'(MAX_NORM_LEN));
   assign data_folded = normalize ? fold(req_data_byte) : req_data_byte;

   always_comb begin
      active_in = active_ff;
      fill_in   = fill_ff;
      total_in  = total_ff;
      push      = 1'b0;
      push_entry.data  = data_folded;
      push_entry.slot  = fill_cur;
      push_entry.take  = take;
      push_entry.last  = req_last;
      push_entry.first = start;
      push_entry.total = total_cur + 32'(take);
      if (accept && (req_byte_present || req_last)) begin
         push = take || req_last;
         if (req_last) begin
            active_in = 1'b0;
            fill_in   = '0;
            total_in  = '0;
         end else begin
            active_in = 1'b1;
            total_in  = push_entry.total;
            if (take) begin
               fill_in = (fill_cur == LAST_SLOT) ? '0 : fill_cur + 1'b1;
            end else begin
               fill_in = fill_cur;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         fill_ff   <= '0;
         total_ff  <= '0;
      end else begin
         active_ff <= active_in;
         fill_ff   <= fill_in;
         total_ff  <= total_in;
      end
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LAST_SLOT)
      else $error("block fill out of range");

endmodule

>>> src/phsh_queue.sv
// ----------------------------------------------------------------------------
// Path string hash: work queue
// Short FIFO of entries between the front and back units.
// ----------------------------------------------------------------------------
module phsh_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  phsh_pkg::entry_type  push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 head_valid,
   output phsh_pkg::entry_type  head_entry
);
   import phsh_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

endmodule

>>> src/phsh_back.sv
// ----------------------------------------------------------------------------
// Path string hash: back unit
// Assembles 12-byte blocks, adds them into the hash words, runs the mix one
// step per cycle, finalizes strings and holds the result register.
// ----------------------------------------------------------------------------
module phsh_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [31:0]          seed,
   input  logic                 head_valid,
   input  phsh_pkg::entry_type  head_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_hash_value
);
   import phsh_pkg::*;

   localparam logic [3:0] STEP_LAST      = 4'd8;
   localparam logic [3:0] STEP_ADD_TOTAL = 4'd9;

   logic [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [7:0]  blk_ff [BLOCK_BYTES];
   logic [7:0]  blk_in [BLOCK_BYTES];
   logic [31:0] tot_ff, tot_in;
   logic [3:0]  step_ff, step_in;
   logic        run_ff, run_in;
   logic        final_ff, final_in;
   logic        pend_ff, pend_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] hash_ff, hash_in;

   logic [31:0] mix_a, mix_b, mix_c;
   logic        out_free;
   logic        plain;
   logic        block_done;
   logic [SLOT_W-1:0] tail_n;
   logic [7:0]  cur [BLOCK_BYTES];
   logic [7:0]  tm  [BLOCK_BYTES];
   logic [31:0] a0, b0, c0;
   logic [31:0] w0, w1, w2, t0, t1, t2;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign block_done = head_entry.take && (head_entry.slot == LAST_SLOT);
   assign plain      = !head_entry.first && !head_entry.last && !block_done;
   assign pop        = head_valid && (!run_ff || plain);
   assign tail_n     = head_entry.take ? head_entry.slot + 1'b1 : head_entry.slot;

   assign a0 = head_entry.first ? GOLDEN : a_ff;
   assign b0 = head_entry.first ? GOLDEN : b_ff;
   assign c0 = head_entry.first ? seed   : c_ff;

   always_comb begin
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         cur[i] = (head_entry.take && head_entry.slot == SLOT_W'(i)) ?
                  head_entry.data : blk_ff[i];
         tm[i]  = (SLOT_W'(i) < tail_n) ? cur[i] : 8'h00;
      end
   end

   assign w0 = {cur[3], cur[2], cur[1], cur[0]};
   assign w1 = {cur[7], cur[6], cur[5], cur[4]};
   assign w2 = {cur[11], cur[10], cur[9], cur[8]};
   assign t0 = {tm[3], tm[2], tm[1], tm[0]};
   assign t1 = {tm[7], tm[6], tm[5], tm[4]};
   assign t2 = {tm[10], tm[9], tm[8], 8'h00};

   // One mix step per cycle; the last step of a final mix waits for the result register to be free
   always_comb begin
      mix_a = a_ff;
      mix_b = b_ff;
      mix_c = c_ff;
      unique case (step_ff)
         4'd0:    mix_a = (a_ff - b_ff - c_ff) ^ (c_ff >> 13);
         4'd1:    mix_b = (b_ff - c_ff - a_ff) ^ (a_ff << 8);
         4'd2:    mix_c = (c_ff - a_ff - b_ff) ^ (b_ff >> 13);
         4'd3:    mix_a = (a_ff - b_ff - c_ff) ^ (c_ff >> 12);
         4'd4:    mix_b = (b_ff - c_ff - a_ff) ^ (a_ff << 16);
         4'd5:    mix_c = (c_ff - a_ff - b_ff) ^ (b_ff >> 5);
         4'd6:    mix_a = (a_ff - b_ff - c_ff) ^ (c_ff >> 3);
         4'd7:    mix_b = (b_ff - c_ff - a_ff) ^ (a_ff << 10);
         4'd8:    mix_c = (c_ff - a_ff - b_ff) ^ (b_ff >> 15);
         default: ;
      endcase
   end

   always_comb begin
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      blk_in       = blk_ff;
      tot_in       = tot_ff;
      step_in      = step_ff;
      run_in       = run_ff;
      final_in     = final_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      hash_in      = hash_ff;

      if (run_ff) begin
         if (step_ff == STEP_ADD_TOTAL) begin
            c_in     = c_ff + tot_ff;
            step_in  = '0;
            final_in = 1'b1;
         end else if (step_ff == STEP_LAST) begin
            if (final_ff) begin
               if (out_free) begin
                  c_in         = mix_c;
                  hash_in      = mix_c;
                  rsp_valid_in = 1'b1;
                  run_in       = 1'b0;
                  final_in     = 1'b0;
               end
            end else begin
               c_in = mix_c;
               if (pend_ff) begin
                  step_in = STEP_ADD_TOTAL;
                  pend_in = 1'b0;
               end else begin
                  run_in = 1'b0;
               end
            end
         end else begin
            a_in    = mix_a;
            b_in    = mix_b;
            c_in    = mix_c;
            step_in = step_ff + 1'b1;
         end
      end

      if (pop) begin
         blk_in = cur;
         if (block_done) begin
            a_in    = a0 + w0;
            b_in    = b0 + w1;
            c_in    = c0 + w2;
            step_in = '0;
            run_in  = 1'b1;
            final_in = 1'b0;
            pend_in = head_entry.last;
            tot_in  = head_entry.total;
         end else if (head_entry.last) begin
            a_in     = a0 + t0;
            b_in     = b0 + t1;
            c_in     = c0 + head_entry.total + t2;
            step_in  = '0;
            run_in   = 1'b1;
            final_in = 1'b1;
            pend_in  = 1'b0;
         end else if (head_entry.first) begin
            a_in = a0;
            b_in = b0;
            c_in = c0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         run_ff       <= 1'b0;
         final_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         run_ff       <= run_in;
         final_ff     <= final_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      blk_ff  <= blk_in;
      tot_ff  <= tot_in;
      hash_ff <= hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = hash_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> step_ff <= STEP_ADD_TOTAL)
      else $error("mix step out of range");

   a_pop_while_mixing: assert property (@(posedge clock) disable iff (reset)
      (pop && run_ff) |-> plain)
      else $error("hash words touched during mix");

   a_final_not_pending: assert property (@(posedge clock) disable iff (reset)
      (run_ff && final_ff) |-> !pend_ff)
      else $error("final mix with pending total");

endmodule
